@@ rtl/spc_pkg.sv @@
package spc_pkg;

  // Widths of the pixel components and of the configuration registers.
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned HUE_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_LOW  = 1'b0,
    CFG_HUE_HIGH = 1'b1
  } cfg_index_t;

  // Reset values of the hue limits.
  localparam logic [HUE_W-1:0] HUE_LOW_RESET  = 8'd25;
  localparam logic [HUE_W-1:0] HUE_HIGH_RESET = 8'd230;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

@@ rtl/spc_if.sv @@
// Pixel channel: one RGB pixel per beat.
interface spc_pixel_if;
  import spc_pkg::*;

  logic valid;
  logic ready;
  pix_t red;
  pix_t green;
  pix_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Result channel: one skin flag per beat.
interface spc_result_if;
  logic valid;
  logic ready;
  logic is_skin;

  modport source (output valid, output is_skin, input ready);
  modport sink   (input valid, input is_skin, output ready);
endinterface

@@ rtl/skin_pixel_classifier_unit.sv @@
// Skin pixel classifier.
// The block takes one RGB pixel per beat on in_chan and returns one skin flag
// per beat on out_chan, in the same order. A pixel is skin when the RGB rule
// (daylight or flash), the Cr/Cb bounds of full-range BT.601 and the hue
// window all pass. The user must write the hue limits through the cfg_ port
// (index 0 low limit, index 1 high limit) only while the block is idle; the
// block itself does not enforce this. The datapath is a three-stage pipeline:
// luma, RGB rule and hue numerator first, chroma and the hue products second,
// then the Cr/Cb bounds, the hue compare and the final AND into the output
// register. A pixel passes stage 1, stage 2 and the output register before
// out_chan.valid rises; a new pixel may be accepted in every cycle unless every
// stage is full and out_chan.ready is low, so throughput is one pixel per cycle.
// When the receiver holds out_chan.ready low, the result stays in the output
// register and the earlier stages keep filling until every stage is full;
// only then does in_chan.ready fall. Nothing is lost or repeated.
// Reset (rst_n low at a clock edge) empties the pipeline and sets the hue
// limits to 25 and 230.
module skin_pixel_classifier_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  spc_pixel_if.sink                      in_chan,
  spc_result_if.source                   out_chan,
  input  logic                           cfg_we,
  input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import spc_pkg::*;

  // Luma and chroma coefficients, 14-bit fixed point.
  localparam logic [21:0] Y_R_COEF = 22'd4899;
  localparam logic [21:0] Y_G_COEF = 22'd9617;
  localparam logic [21:0] Y_B_COEF = 22'd1868;
  localparam logic [21:0] Y_ROUND  = 22'd8192;
  localparam logic signed [23:0] CR_COEF     = 24'sd11682;
  localparam logic signed [23:0] CB_COEF     = 24'sd9241;
  localparam logic signed [23:0] CHROMA_BIAS = 24'sd2105344;

  // Cr/Cb bound coefficients, scaled by 10000.
  localparam logic signed [25:0] CR_SCALE = 26'sd10000;
  localparam logic signed [25:0] B1_SLOPE = 26'sd15862;
  localparam logic signed [25:0] B1_OFFS  = 26'sd200000;
  localparam logic signed [25:0] B2_SLOPE = 26'sd3448;
  localparam logic signed [25:0] B2_OFFS  = 26'sd762069;
  localparam logic signed [25:0] B3_SLOPE = 26'sd45652;
  localparam logic signed [25:0] B3_OFFS  = 26'sd2345652;
  localparam logic signed [25:0] B4_SLOPE = 26'sd11500;
  localparam logic signed [25:0] B4_OFFS  = 26'sd3017500;
  localparam logic signed [25:0] B5_SLOPE = 26'sd22857;
  localparam logic signed [25:0] B5_OFFS  = 26'sd4328500;

  // RGB rule thresholds.
  localparam pix_t DAY_R_MIN   = 8'd95;
  localparam pix_t DAY_G_MIN   = 8'd40;
  localparam pix_t DAY_B_MIN   = 8'd20;
  localparam pix_t SPREAD_MIN  = 8'd15;
  localparam pix_t FLASH_R_MIN = 8'd220;
  localparam pix_t FLASH_G_MIN = 8'd210;
  localparam pix_t FLASH_B_MIN = 8'd170;

  // Clamps a chroma accumulator to 0..255 and takes its integer part.
  function automatic pix_t chroma_sat(input logic signed [23:0] acc);
    pix_t res;
    if (acc[23]) begin
      res = '0;
    end else if (acc[22]) begin
      res = '1;
    end else begin
      res = acc[21:14];
    end
    return res;
  endfunction

  // Configuration registers.
  logic [HUE_W-1:0] hue_low_r;
  logic [HUE_W-1:0] hue_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= HUE_LOW_RESET;
      hue_high_r <= HUE_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_HUE_LOW:  hue_low_r  <= cfg_wdata[HUE_W-1:0];
        CFG_HUE_HIGH: hue_high_r <= cfg_wdata[HUE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its contents move on.
  logic v1_r, v2_r, v3_r;
  logic load1, load2, load3;

  assign load3 = !v3_r || out_chan.ready;
  assign load2 = !v2_r || load3;
  assign load1 = !v1_r || load2;
  assign in_chan.ready = load1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (load1) v1_r <= in_chan.valid;
      if (load2) v2_r <= v1_r;
      if (load3) v3_r <= v2_r;
    end
  end

  // Stage 1: luma, RGB rule, hue numerator and chroma spread.
  pix_t r, g, b;
  pix_t mx, mn, spread, rg_abs;
  logic [21:0] luma_sum;
  logic [16:0] d17;
  logic        day_ok, flash_ok;
  logic [16:0] hue_n_nxt;

  assign r = in_chan.red;
  assign g = in_chan.green;
  assign b = in_chan.blue;

  always_comb begin
    mx       = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn       = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    spread   = mx - mn;
    rg_abs   = (r > g) ? (r - g) : (g - r);
    luma_sum = 22'(r) * Y_R_COEF + 22'(g) * Y_G_COEF + 22'(b) * Y_B_COEF + Y_ROUND;
    day_ok   = (r > DAY_R_MIN) && (g > DAY_G_MIN) && (b > DAY_B_MIN) &&
               (spread > SPREAD_MIN) && (rg_abs > SPREAD_MIN) && (r > g) && (r > b);
    flash_ok = (r > FLASH_R_MIN) && (g > FLASH_G_MIN) && (b > FLASH_B_MIN) &&
               (rg_abs <= SPREAD_MIN) && (r > b) && (g > b);
    d17      = 17'(spread);
    // Hue numerator: the hue in degrees times the spread; red wins ties,
    // then green. The result is never negative, so wrapping sums are exact.
    if (r >= g && r >= b) begin
      if (g >= b) begin
        hue_n_nxt = (17'(g) - 17'(b)) * 17'd60;
      end else begin
        hue_n_nxt = d17 * 17'd360 - (17'(b) - 17'(g)) * 17'd60;
      end
    end else if (g >= b) begin
      hue_n_nxt = d17 * 17'd120 + 17'(b) * 17'd60 - 17'(r) * 17'd60;
    end else begin
      hue_n_nxt = d17 * 17'd240 + 17'(r) * 17'd60 - 17'(g) * 17'd60;
    end
  end

  pix_t        s1_red_r, s1_blue_r, s1_luma_r, s1_spread_r;
  logic        s1_rgb_ok_r;
  logic [16:0] s1_hue_n_r;

  always_ff @(posedge clk) begin
    if (load1 && in_chan.valid) begin
      s1_red_r    <= r;
      s1_blue_r   <= b;
      s1_luma_r   <= luma_sum[21:14];
      s1_spread_r <= spread;
      s1_rgb_ok_r <= day_ok || flash_ok;
      s1_hue_n_r  <= hue_n_nxt;
    end
  end

  // Stage 2: chroma with saturation and the hue products.
  logic signed [8:0]  cr_diff, cb_diff;
  logic signed [23:0] cr_acc, cb_acc;

  always_comb begin
    cr_diff = signed'({1'b0, s1_red_r})  - signed'({1'b0, s1_luma_r});
    cb_diff = signed'({1'b0, s1_blue_r}) - signed'({1'b0, s1_luma_r});
    cr_acc  = 24'(cr_diff) * CR_COEF + CHROMA_BIAS;
    cb_acc  = 24'(cb_diff) * CB_COEF + CHROMA_BIAS;
  end

  pix_t        s2_cr_r, s2_cb_r;
  logic        s2_rgb_ok_r;
  logic [20:0] s2_hue_n17_r;
  logic [15:0] s2_low_d_r, s2_high_d_r;

  always_ff @(posedge clk) begin
    if (load2 && v1_r) begin
      s2_cr_r      <= chroma_sat(cr_acc);
      s2_cb_r      <= chroma_sat(cb_acc);
      s2_rgb_ok_r  <= s1_rgb_ok_r;
      s2_hue_n17_r <= 21'(s1_hue_n_r) * 21'd17;
      s2_low_d_r   <= 16'(hue_low_r) * 16'(s1_spread_r);
      s2_high_d_r  <= 16'(hue_high_r) * 16'(s1_spread_r);
    end
  end

  // Stage 3: Cr/Cb bounds, hue window and the final flag.
  logic signed [25:0] cr_s, cb_s, cr_scaled;
  logic               crcb_ok, hue_ok;
  logic [20:0]        low_lim, high_lim;

  always_comb begin
    cr_s      = signed'({18'd0, s2_cr_r});
    cb_s      = signed'({18'd0, s2_cb_r});
    cr_scaled = cr_s * CR_SCALE;
    crcb_ok   = (cr_scaled <= cb_s * B1_SLOPE + B1_OFFS) &&
                (cr_scaled >= cb_s * B2_SLOPE + B2_OFFS) &&
                (cr_scaled >= B3_OFFS - cb_s * B3_SLOPE) &&
                (cr_scaled <= B4_OFFS - cb_s * B4_SLOPE) &&
                (cr_scaled <= B5_OFFS - cb_s * B5_SLOPE);
    // Times 24 as two shifted copies.
    low_lim   = 21'({s2_low_d_r, 4'b0}) + 21'({s2_low_d_r, 3'b0});
    high_lim  = 21'({s2_high_d_r, 4'b0}) + 21'({s2_high_d_r, 3'b0});
    hue_ok    = (s2_hue_n17_r < low_lim) || (s2_hue_n17_r > high_lim);
  end

  logic skin_r;

  always_ff @(posedge clk) begin
    if (load3 && v2_r) begin
      skin_r <= s2_rgb_ok_r && crcb_ok && hue_ok;
    end
  end

  assign out_chan.valid   = v3_r;
  assign out_chan.is_skin = skin_r;

endmodule
